// ===== hdl/bsfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the byte-stuffed frame decoder.
// Depends on nothing; used by bsfd_core, bsfd_skid and byte_stuffing_frame_decoder.

package bsfd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEFAULT = 64;
    localparam int unsigned LEN_W               = 7;

    localparam logic [7:0] START_BYTE = 8'hF7;
    localparam logic [7:0] END_BYTE   = 8'h7F;
    localparam logic [7:0] ESC_BYTE   = 8'hF6;
    localparam logic [7:0] ESC_FLIP   = 8'h20;
    localparam logic [7:0] SUM_INIT   = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_SUM = 2'd1,
        STATUS_SHORT   = 2'd2,
        STATUS_LONG    = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             frame_end;
        frame_status_t    frame_status;
        logic [LEN_W-1:0] payload_length;
    } bsfd_result_t;

endpackage

// ===== hdl/bsfd_core.sv =====
`timescale 1ns / 1ps
// Frame decoding state: unstuffing, two-byte hold line, Fletcher-16 and end status.
// Depends on bsfd_pkg.

module bsfd_core #(
    parameter int unsigned MAX_PAYLOAD = bsfd_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             rx_byte,
    output logic                   result_valid,
    output bsfd_pkg::bsfd_result_t result
);
    import bsfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned EXT_W = CNT_W + LEN_W;

    logic             in_frame_reg, in_frame_next;
    logic             escape_reg, escape_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       held_count_reg, held_count_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_low_reg, sum_low_next;
    logic [7:0]       sum_high_reg, sum_high_next;
    logic             overflowed_reg, overflowed_next;

    logic [7:0]       data_byte;
    logic             is_data;
    logic [7:0]       sum_low_upd;
    logic [CNT_W-1:0] count_inc;

    // End-around (ones' complement) add for mod-255 sums.
    function automatic logic [7:0] add255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    assign sum_low_upd = add255(sum_low_reg, held0_reg);
    assign count_inc   = count_reg + 1'b1;

    always_comb begin
        in_frame_next   = in_frame_reg;
        escape_next     = escape_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        count_next      = count_reg;
        sum_low_next    = sum_low_reg;
        sum_high_next   = sum_high_reg;
        overflowed_next = overflowed_reg;
        result_valid    = 1'b0;
        result          = '{out_byte: 8'd0, frame_end: 1'b0,
                            frame_status: STATUS_OK, payload_length: '0};
        data_byte       = rx_byte;
        is_data         = 1'b0;

        if (accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == START_BYTE) begin
                    in_frame_next   = 1'b1;
                    escape_next     = 1'b0;
                    held0_next      = 8'd0;
                    held1_next      = 8'd0;
                    held_count_next = 2'd0;
                    count_next      = '0;
                    sum_low_next    = SUM_INIT;
                    sum_high_next   = SUM_INIT;
                    overflowed_next = 1'b0;
                end
            end else if (rx_byte == END_BYTE) begin
                // A pending escape is simply dropped by the end byte.
                in_frame_next    = 1'b0;
                escape_next      = 1'b0;
                result_valid     = 1'b1;
                result.frame_end = 1'b1;
                result.payload_length = LEN_W'(EXT_W'(count_reg));
                if (held_count_reg < 2'd2) begin
                    result.frame_status   = STATUS_SHORT;
                    result.payload_length = '0;
                end else if (overflowed_reg) begin
                    result.frame_status = STATUS_LONG;
                end else if (held0_reg != sum_low_reg || held1_reg != sum_high_reg) begin
                    result.frame_status = STATUS_BAD_SUM;
                end else begin
                    result.frame_status = STATUS_OK;
                end
            end else if (escape_reg) begin
                escape_next = 1'b0;
                data_byte   = rx_byte ^ ESC_FLIP;
                is_data     = 1'b1;
            end else if (rx_byte == ESC_BYTE) begin
                escape_next = 1'b1;
            end else begin
                is_data = 1'b1;
            end

            if (is_data) begin
                if (held_count_reg < 2'd2) begin
                    if (held_count_reg[0]) begin
                        held1_next = data_byte;
                    end else begin
                        held0_next = data_byte;
                    end
                    held_count_next = held_count_reg + 2'd1;
                end else begin
                    held0_next = held1_reg;
                    held1_next = data_byte;
                    if (!overflowed_reg) begin
                        if (count_reg >= CNT_W'(MAX_PAYLOAD)) begin
                            overflowed_next = 1'b1;
                        end else begin
                            sum_low_next          = sum_low_upd;
                            sum_high_next         = add255(sum_high_reg, sum_low_upd);
                            count_next            = count_inc;
                            result_valid          = 1'b1;
                            result.out_byte       = held0_reg;
                            result.payload_length = LEN_W'(EXT_W'(count_inc));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            escape_reg     <= 1'b0;
            held0_reg      <= 8'd0;
            held1_reg      <= 8'd0;
            held_count_reg <= 2'd0;
            count_reg      <= '0;
            sum_low_reg    <= SUM_INIT;
            sum_high_reg   <= SUM_INIT;
            overflowed_reg <= 1'b0;
        end else begin
            in_frame_reg   <= in_frame_next;
            escape_reg     <= escape_next;
            held0_reg      <= held0_next;
            held1_reg      <= held1_next;
            held_count_reg <= held_count_next;
            count_reg      <= count_next;
            sum_low_reg    <= sum_low_next;
            sum_high_reg   <= sum_high_next;
            overflowed_reg <= overflowed_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count above maximum");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid && result.frame_end |=> !in_frame_reg && !escape_reg)
        else $error("frame still open after end result");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> count_reg == CNT_W'(MAX_PAYLOAD))
        else $error("overflow flagged below maximum length");

endmodule

// ===== hdl/bsfd_skid.sv =====
`timescale 1ns / 1ps
// Output register with one skid entry, so a beat can be taken while the result waits.
// Depends on bsfd_pkg.

module bsfd_skid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bsfd_pkg::bsfd_result_t push_data,
    output logic                   can_push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bsfd_pkg::bsfd_result_t out_data
);
    import bsfd_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    bsfd_result_t out_data_reg, out_data_next;
    bsfd_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        push && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

// ===== hdl/byte_stuffing_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame decoder with Fletcher-16 check.
// Depends on bsfd_pkg, bsfd_core and bsfd_skid.
//
// Usage:
// Raw received bytes enter as beats on the s_ channel (s_valid, s_ready,
// s_rx_byte), one byte per beat. Outside a frame every byte is discarded
// until the start byte 0xF7. Inside a frame, 0xF6 escapes the next byte
// and 0x7F closes the frame. Confirmed payload bytes leave on the m_
// channel with m_frame_end low and a running length; the closing beat has
// m_frame_end high, the frame status and the payload length.
// Each result is registered in the output register, or in the skid entry
// while the receiver stalls, before it shows on the m_ channel. Throughput:
// one input beat per cycle while s_ready is high, through the decode step
// (a compare and two 8-bit end-around adds) before the output register.
// Reset (aresetn low at a clock edge) returns the decoder to idle and
// discards any result that is waiting.
// When the receiver stalls, one result waits in the output register and
// a second is caught in a skid entry; s_ready falls only while that skid
// entry is occupied, and rises again once the receiver takes a beat.

module byte_stuffing_frame_decoder #(
    parameter int unsigned MAX_PAYLOAD = bsfd_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_out_byte,
    output logic                         m_frame_end,
    output logic [1:0]                   m_frame_status,
    output logic [bsfd_pkg::LEN_W-1:0]   m_payload_length
);
    import bsfd_pkg::*;

    logic         accept;
    logic         result_valid;
    bsfd_result_t result;
    bsfd_result_t out_data;

    // A beat is taken whenever s_valid is high and the skid entry has room for whatever it causes.
    assign accept = s_valid && s_ready;

    // Decoder state and the per-beat decode step.
    bsfd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .rx_byte      (s_rx_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    // Result register plus skid entry towards the receiver.
    bsfd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (result_valid),
        .push_data (result),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_out_byte       = out_data.out_byte;
    assign m_frame_end      = out_data.frame_end;
    assign m_frame_status   = 2'(out_data.frame_status);
    assign m_payload_length = out_data.payload_length;

    a_end_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_out_byte == 8'd0)
        else $error("end beat carries a data byte");

    a_data_beat_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_frame_status == 2'(STATUS_OK)
                                    && m_payload_length != '0)
        else $error("payload beat with status or zero length");

    a_short_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end && m_frame_status == 2'(STATUS_SHORT)
            |-> m_payload_length == '0)
        else $error("short frame reports a length");

endmodule
